FILE: rtl/core/scp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scp_pkg;

  localparam int SCREEN_HEIGHT_DEF = 720;

  localparam int IN_W      = 96;
  localparam int OUT_W     = 160;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PLAYER_X   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLAYER_Y   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y      = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_X    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INV_DET    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH = 4'd7;

  localparam logic signed [31:0] DIR_X_RST      = 32'sd65536;
  localparam logic signed [31:0] PLANE_Y_RST    = 32'sd43254;
  localparam logic signed [31:0] INV_DET_RST    = 32'sd65536;
  localparam logic [11:0]        HALF_WIDTH_RST = 12'd320;

  localparam logic signed [15:0] COL_MAX = 16'sh7fff;
  localparam logic signed [15:0] COL_MIN = 16'sh8000;

  typedef struct packed {
    logic [7:0] next_tick;
    logic [3:0] next_frame;
    logic       advanced;
  } anim_t;

  typedef struct packed {
    logic zero;
    logic zpos;
    logic hovf;
    logic covf;
    logic cneg;
  } proj_flags_t;

  typedef struct packed {
    logic signed [15:0] column;
    logic [15:0]        height;
  } proj_t;

  // clamp a 49-bit signed value to 32-bit signed
  function automatic logic signed [31:0] sat49(input logic signed [48:0] v);
    logic [16:0] hi;
    hi = v[48:32];
    if (hi == {17{v[31]}}) return v[31:0];
    else if (v[48]) return 32'sh80000000;
    else return 32'sh7fffffff;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/scp_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module scp_isqrt #(
  parameter int IW = 64
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [IW-1:0]     n,
  output logic      [IW/2-1:0]   root
);

  localparam int RW = IW / 2;

  logic [IW-1:0] n_q    [RW];
  logic [RW:0]   rem_q  [RW];
  logic [RW-1:0] root_q [RW];

  // one result bit per stage, two radicand bits consumed each time
  for (genvar g = 0; g < RW; g++) begin : g_stage
    logic [IW-1:0] n_in;
    logic [RW:0]   rem_in;
    logic [RW-1:0] root_in;
    logic [RW+2:0] t;
    logic [RW+2:0] trial;

    if (g == 0) begin : g_first
      assign n_in    = n;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign n_in    = n_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
    end

    assign t     = {rem_in, n_in[IW-1-2*g -: 2]};
    assign trial = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        n_q[g] <= n_in;
        if (t >= trial) begin
          rem_q[g]  <= (RW+1)'(t - trial);
          root_q[g] <= {root_in[RW-2:0], 1'b1};
        end else begin
          rem_q[g]  <= t[RW:0];
          root_q[g] <= {root_in[RW-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_q[RW-1];

endmodule

`default_nettype wire

FILE: rtl/core/scp_div.sv
`timescale 1ns / 1ps
`default_nettype none

module scp_div #(
  parameter int DW = 32,
  parameter int QW = 16
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [DW-1:0] rem0,
  input  wire logic [QW-1:0] low,
  input  wire logic [DW-1:0] divisor,
  output logic      [QW-1:0] quot
);

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] low_q [QW];
  logic [DW-1:0] d_q   [QW];
  logic [QW-1:0] q_q   [QW];

  // restoring division, one quotient bit per stage
  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    logic [DW:0]   t;

    if (g == 0) begin : g_first
      assign rem_in = rem0;
      assign low_in = low;
      assign d_in   = divisor;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign low_in = low_q[g-1];
      assign d_in   = d_q[g-1];
      assign q_in   = q_q[g-1];
    end

    assign t = {rem_in, low_in[QW-1-g]};

    always_ff @(posedge clk) begin
      if (en) begin
        low_q[g] <= low_in;
        d_q[g]   <= d_in;
        if (t >= {1'b0, d_in}) begin
          rem_q[g] <= DW'(t - {1'b0, d_in});
          q_q[g]   <= {q_in[QW-2:0], 1'b1};
        end else begin
          rem_q[g] <= t[DW-1:0];
          q_q[g]   <= {q_in[QW-2:0], 1'b0};
        end
      end
    end
  end

  assign quot = q_q[QW-1];

endmodule

`default_nettype wire

FILE: rtl/core/sprite_camera_projection_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// throughput: one request per cycle; the 32-stage square root sets the depth
// a stalled master side freezes the whole pipeline, nothing is dropped
// rst (synchronous) empties the pipeline and loads the camera register defaults

module sprite_camera_projection_unit
  import scp_pkg::*;
#(
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // ent_x, ent_y, tick_count, frame_rate, frame_index, frames_in_loop, zero pad
  input  wire logic [IN_W-1:0]      s_tdata,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // distance, lateral, depth, screen_column, projected height, half of that height,
  // next_tick_count, next_frame_index, frame_advanced, zero pad
  output logic      [OUT_W-1:0]     m_tdata,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int SQ_STAGES  = 32;
  localparam int DIV_STAGES = 16;
  localparam int LAST       = 3 + SQ_STAGES;
  localparam int LD_DLY     = LAST - 5;
  localparam int FIN_DLY    = LAST - 8 - DIV_STAGES;
  localparam logic [47:0] H_NUM = 48'(SCREEN_HEIGHT) << 16;

  // camera registers
  logic signed [31:0] player_x, player_y, dir_x, dir_y, plane_x, plane_y, inv_det;
  logic [11:0]        half_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      player_x   <= '0;
      player_y   <= '0;
      dir_x      <= DIR_X_RST;
      dir_y      <= '0;
      plane_x    <= '0;
      plane_y    <= PLANE_Y_RST;
      inv_det    <= INV_DET_RST;
      half_width <= HALF_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PLAYER_X:   player_x   <= cfg_data;
        REG_PLAYER_Y:   player_y   <= cfg_data;
        REG_DIR_X:      dir_x      <= cfg_data;
        REG_DIR_Y:      dir_y      <= cfg_data;
        REG_PLANE_X:    plane_x    <= cfg_data;
        REG_PLANE_Y:    plane_y    <= cfg_data;
        REG_INV_DET:    inv_det    <= cfg_data;
        REG_HALF_WIDTH: half_width <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [LAST:1] vld;
  logic          en;

  assign en       = !vld[LAST] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAST-1:1], s_tvalid};
  end

  // input fields
  logic signed [31:0] ent_x, ent_y;
  logic [7:0]         tick_count, frame_rate;
  logic [3:0]         frame_index;
  logic [4:0]         frames_in_loop;

  assign ent_x          = s_tdata[31:0];
  assign ent_y          = s_tdata[63:32];
  assign tick_count     = s_tdata[71:64];
  assign frame_rate     = s_tdata[79:72];
  assign frame_index    = s_tdata[83:80];
  assign frames_in_loop = s_tdata[88:84];

  // animation step
  anim_t      anim_c;
  logic [8:0] tick_inc;
  logic [4:0] loop_len;
  logic [4:0] frame_inc;

  always_comb begin
    tick_inc  = {1'b0, tick_count} + 9'd1;
    loop_len  = (frames_in_loop == 5'd0 || frames_in_loop > 5'd16) ? 5'd16 : frames_in_loop;
    frame_inc = {1'b0, frame_index} + 5'd1;
    anim_c.advanced   = (tick_inc == {1'b0, frame_rate});
    anim_c.next_tick  = anim_c.advanced ? 8'd0 : tick_inc[7:0];
    anim_c.next_frame = !anim_c.advanced ? frame_index :
                        (frame_inc >= loop_len) ? 4'd0 : frame_inc[3:0];
  end

  anim_t anim_d [LAST];

  always_ff @(posedge clk) begin
    if (en) begin
      anim_d[0] <= anim_c;
      for (int i = 1; i < LAST; i++) anim_d[i] <= anim_d[i-1];
    end
  end

  // stage 1: offset from player
  logic signed [31:0] dx1, dy1;
  logic signed [32:0] dx_full, dy_full;

  assign dx_full = 33'(ent_x) - 33'(player_x);
  assign dy_full = 33'(ent_y) - 33'(player_y);

  // stage 2: products, stage 3: camera sums and squared length
  logic signed [63:0] p_ly2, p_lx2, p_dx2, p_dy2;
  logic [63:0]        sq_x2, sq_y2;
  logic signed [31:0] tl3, td3;
  logic [63:0]        sumsq3;
  logic signed [64:0] dl_diff, dd_diff;

  assign dl_diff = 65'(p_ly2) - 65'(p_lx2);
  assign dd_diff = 65'(p_dx2) - 65'(p_dy2);

  // stage 4: inverse determinant, stage 5: camera space
  logic signed [63:0] ml4, md4;
  logic signed [31:0] lat5, dep5;

  // stage 6..8: projection setup
  logic signed [32:0] sum6;
  logic [31:0]        mag6, mag7, mag8;
  logic               zero6, zpos6, hovf6, dneg6;
  logic               zero7, zpos7, hovf7, dneg7;
  logic               zero8, zpos8, hovf8, cneg8;
  logic signed [45:0] num7;
  logic [44:0]        anum8;

  always_ff @(posedge clk) begin
    if (en) begin
      dx1    <= sat49(49'(dx_full));
      dy1    <= sat49(49'(dy_full));

      p_ly2  <= 64'(dir_y) * 64'(dx1);
      p_lx2  <= 64'(dir_x) * 64'(dy1);
      p_dx2  <= 64'(plane_x) * 64'(dy1);
      p_dy2  <= 64'(plane_y) * 64'(dx1);
      sq_x2  <= 64'(64'(dx1) * 64'(dx1));
      sq_y2  <= 64'(64'(dy1) * 64'(dy1));

      tl3    <= sat49(49'(dl_diff >>> 16));
      td3    <= sat49(49'(dd_diff >>> 16));
      sumsq3 <= sq_x2 + sq_y2;

      ml4    <= 64'(inv_det) * 64'(tl3);
      md4    <= 64'(inv_det) * 64'(td3);

      lat5   <= sat49(49'(ml4 >>> 16));
      dep5   <= sat49(49'(md4 >>> 16));

      sum6   <= 33'(dep5) + 33'(lat5);
      mag6   <= dep5[31] ? (~dep5 + 32'd1) : dep5;
      zero6  <= (dep5 == 32'sd0);
      zpos6  <= (half_width == 12'd0) || !lat5[31];
      hovf6  <= H_NUM[47:16] >= (dep5[31] ? (~dep5 + 32'd1) : dep5);
      dneg6  <= dep5[31];

      num7   <= 46'($signed({1'b0, half_width})) * 46'(sum6);
      mag7   <= mag6;
      zero7  <= zero6;
      zpos7  <= zpos6;
      hovf7  <= hovf6;
      dneg7  <= dneg6;

      anum8  <= num7[45] ? 45'(-num7) : 45'(num7);
      cneg8  <= num7[45] ^ dneg7;
      mag8   <= mag7;
      zero8  <= zero7;
      zpos8  <= zpos7;
      hovf8  <= hovf7;
    end
  end

  // distance
  logic [31:0] dist_root;

  scp_isqrt #(
    .IW (64)
  ) u_isqrt (
    .clk  (clk),
    .en   (en),
    .n    (sumsq3),
    .root (dist_root)
  );

  // column and height dividers
  logic [DIV_STAGES-1:0] col_q, hgt_q;

  scp_div #(
    .DW (32),
    .QW (DIV_STAGES)
  ) u_col_div (
    .clk     (clk),
    .en      (en),
    .rem0    ({3'b0, anum8[44:16]}),
    .low     (anum8[15:0]),
    .divisor (mag8),
    .quot    (col_q)
  );

  scp_div #(
    .DW (32),
    .QW (DIV_STAGES)
  ) u_hgt_div (
    .clk     (clk),
    .en      (en),
    .rem0    (H_NUM[47:16]),
    .low     (H_NUM[15:0]),
    .divisor (mag8),
    .quot    (hgt_q)
  );

  proj_flags_t flags_c;
  proj_flags_t flags_d [DIV_STAGES];

  always_comb begin
    flags_c.zero = zero8;
    flags_c.zpos = zpos8;
    flags_c.hovf = hovf8;
    flags_c.covf = {3'b0, anum8[44:16]} >= mag8;
    flags_c.cneg = cneg8;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flags_d[0] <= flags_c;
      for (int i = 1; i < DIV_STAGES; i++) flags_d[i] <= flags_d[i-1];
    end
  end

  // saturate and sign the quotients
  proj_t       fin_c;
  proj_flags_t fl;

  always_comb begin
    fl = flags_d[DIV_STAGES-1];
    if (fl.zero) begin
      fin_c.column = fl.zpos ? COL_MAX : COL_MIN;
      fin_c.height = 16'hffff;
    end else begin
      fin_c.height = fl.hovf ? 16'hffff : hgt_q;
      if (fl.covf) fin_c.column = fl.cneg ? COL_MIN : COL_MAX;
      else if (fl.cneg) fin_c.column = (col_q > 16'h8000) ? COL_MIN : -$signed(col_q);
      else fin_c.column = (col_q > 16'h7fff) ? COL_MAX : $signed(col_q);
    end
  end

  proj_t fin_d [FIN_DLY];
  logic signed [31:0] lat_d [LD_DLY];
  logic signed [31:0] dep_d [LD_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      fin_d[0] <= fin_c;
      for (int i = 1; i < FIN_DLY; i++) fin_d[i] <= fin_d[i-1];
      lat_d[0] <= lat5;
      dep_d[0] <= dep5;
      for (int i = 1; i < LD_DLY; i++) begin
        lat_d[i] <= lat_d[i-1];
        dep_d[i] <= dep_d[i-1];
      end
    end
  end

  proj_t fin_o;
  anim_t anim_o;

  assign fin_o  = fin_d[FIN_DLY-1];
  assign anim_o = anim_d[LAST-1];

  assign m_tdata = {4'b0, anim_o.advanced, anim_o.next_frame, anim_o.next_tick,
                    fin_o.height[15:1], fin_o.height, fin_o.column,
                    dep_d[LD_DLY-1], lat_d[LD_DLY-1], dist_root};

  a_ready_follows_stall: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("ready does not follow the output stall");

  a_reset_empties: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_zero_depth_height: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && dep_d[LD_DLY-1] == 32'sd0 |-> fin_o.height == 16'hffff)
    else $error("zero depth without saturated height");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved during a stall");

endmodule

`default_nettype wire
